/* design/tcpoce_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcpoce_pkg
// Shared constants and types for the TCP option client address extractor.
// ----------------------------------------------------------------------------
package tcpoce_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 8;
  localparam int unsigned SIZE_W      = 6;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned ADDR_W      = PORT_W + IP_W;
  localparam int unsigned CAP_BYTES   = ADDR_W / BYTE_W;
  localparam int unsigned CAP_IDX_W   = $clog2(CAP_BYTES + 1);

  localparam logic [BYTE_W-1:0] KIND_EOL         = 8'd0;
  localparam logic [BYTE_W-1:0] KIND_NOP         = 8'd1;
  localparam logic [BYTE_W-1:0] OPT_LEN_MIN      = 8'd2;
  localparam logic [BYTE_W-1:0] OPT_AREA_MAX     = 8'd40;
  localparam logic [BYTE_W-1:0] ADDR_OPT_LEN_MIN = 8'd8;

  localparam logic [KIND_W-1:0] MATCH_KIND_RST = 8'd254;
  localparam logic [SIZE_W-1:0] MATCH_SIZE_RST = 6'd8;

  // APB register map, word aligned
  localparam int unsigned PADDR_W = 3;
  typedef enum logic {
    REG_MATCH_KIND = 1'b0,
    REG_MATCH_SIZE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              found;
    logic [PORT_W-1:0] client_port;
    logic [IP_W-1:0]   client_ip;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_stat_t;

endpackage
`default_nettype wire

/* design/tcpoce_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcpoce_if
// Valid/ready channels for option bytes and extracted results.
// ----------------------------------------------------------------------------
interface tcpoce_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcpoce_pkg::BYTE_W-1:0] option_byte;
  logic                         area_end;

  modport source (output valid, output option_byte, output area_end, input ready);
  modport sink (input valid, input option_byte, input area_end, output ready);
endinterface

interface tcpoce_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [tcpoce_pkg::PORT_W-1:0] client_port;
  logic [tcpoce_pkg::IP_W-1:0]   client_ip;

  modport source (output valid, output found, output client_port, output client_ip,
                  input ready);
  modport sink (input valid, input found, input client_port, input client_ip,
                output ready);
endinterface
`default_nettype wire

/* design/tcpoce_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcpoce_parser
// Input byte register and per-byte option walker with address capture.
// ----------------------------------------------------------------------------
module tcpoce_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  tcpoce_in_if.sink                            option_chan,
  input  wire logic [tcpoce_pkg::KIND_W-1:0]   match_kind,
  input  wire logic [tcpoce_pkg::SIZE_W-1:0]   match_size,
  input  wire logic                            res_ready,
  output tcpoce_pkg::result_stat_t             res
);

  typedef enum logic [1:0] {
    PH_KIND,
    PH_LEN,
    PH_DATA,
    PH_STOP
  } phase_t;

  logic                                stage_valid;
  logic [tcpoce_pkg::BYTE_W-1:0]       stage_byte;
  logic                                stage_last;
  logic                                consume;

  phase_t                              phase, phase_next;
  logic [tcpoce_pkg::SIZE_W-1:0]       left, left_next;
  logic                                hit, hit_next;
  logic [tcpoce_pkg::ADDR_W-1:0]       cap, cap_next;
  logic [tcpoce_pkg::CAP_IDX_W-1:0]    idx, idx_next;
  logic                                found, found_next;
  logic [tcpoce_pkg::ADDR_W-1:0]       addr, addr_next;

  assign consume           = stage_valid && (!stage_last || res_ready);
  assign option_chan.ready = !stage_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (option_chan.valid && option_chan.ready) begin
      stage_valid <= 1'b1;
    end else if (consume) begin
      stage_valid <= 1'b0;
    end
    if (option_chan.valid && option_chan.ready) begin
      stage_byte <= option_chan.option_byte;
      stage_last <= option_chan.area_end;
    end
  end

  always_comb begin
    phase_next = phase;
    left_next  = left;
    hit_next   = hit;
    cap_next   = cap;
    idx_next   = idx;
    found_next = found;
    addr_next  = addr;
    unique case (phase)
      PH_KIND: begin
        if (stage_byte == tcpoce_pkg::KIND_EOL) begin
          phase_next = PH_STOP;
        end else if (stage_byte != tcpoce_pkg::KIND_NOP) begin
          hit_next   = (stage_byte == match_kind);
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        if (stage_byte < tcpoce_pkg::OPT_LEN_MIN || stage_byte > tcpoce_pkg::OPT_AREA_MAX) begin
          phase_next = PH_STOP;
        end else if (stage_byte == tcpoce_pkg::OPT_LEN_MIN) begin
          hit_next   = 1'b0;
          phase_next = PH_KIND;
        end else begin
          hit_next   = hit
                       && (stage_byte == {2'b00, match_size})
                       && (stage_byte >= tcpoce_pkg::ADDR_OPT_LEN_MIN);
          left_next  = tcpoce_pkg::SIZE_W'(stage_byte - tcpoce_pkg::OPT_LEN_MIN);
          idx_next   = '0;
          cap_next   = '0;
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (idx < tcpoce_pkg::CAP_IDX_W'(tcpoce_pkg::CAP_BYTES)) begin
          cap_next = {cap[tcpoce_pkg::ADDR_W-tcpoce_pkg::BYTE_W-1:0], stage_byte};
          idx_next = idx + 1'b1;
        end
        if (left != '0) begin
          left_next = left - 1'b1;
        end
        if (left_next == '0) begin
          if (hit) begin
            found_next = 1'b1;
            addr_next  = cap_next;
          end
          hit_next   = 1'b0;
          phase_next = PH_KIND;
        end
      end
      PH_STOP: begin
      end
      default: begin
      end
    endcase
  end

  // result comes from the walker's next state with the final byte applied
  assign res.valid            = stage_valid && stage_last;
  assign res.data.found       = found_next;
  assign res.data.client_port = found_next ? addr_next[tcpoce_pkg::ADDR_W-1:tcpoce_pkg::IP_W]
                                           : '0;
  assign res.data.client_ip   = found_next ? addr_next[tcpoce_pkg::IP_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst || (consume && stage_last)) begin
      phase <= PH_KIND;
      left  <= '0;
      hit   <= 1'b0;
      cap   <= '0;
      idx   <= '0;
      found <= 1'b0;
      addr  <= '0;
    end else if (consume) begin
      phase <= phase_next;
      left  <= left_next;
      hit   <= hit_next;
      cap   <= cap_next;
      idx   <= idx_next;
      found <= found_next;
      addr  <= addr_next;
    end
  end

endmodule
`default_nettype wire

/* design/tcpoce_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcpoce_out_reg
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module tcpoce_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tcpoce_pkg::result_stat_t res,
  output logic                       res_ready,
  tcpoce_out_if.source               result_chan
);

  logic                 valid;
  tcpoce_pkg::result_t  data;

  assign res_ready = !valid || result_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      valid <= 1'b1;
    end else if (result_chan.ready) begin
      valid <= 1'b0;
    end
    if (res.valid && res_ready) begin
      data <= res.data;
    end
  end

  assign result_chan.valid       = valid;
  assign result_chan.found       = data.found;
  assign result_chan.client_port = data.client_port;
  assign result_chan.client_ip   = data.client_ip;

endmodule
`default_nettype wire

/* design/tcp_option_client_addr_extract.sv */
// Throughput: one option byte per cycle, unless a held result stalls the input register;
// the next area may start right behind the last.
// Each byte passes an input register and then the walker logic; results go to the result register.
// A result held by the receiver keeps the final byte in the input register and stalls input.
// Reset (rst, synchronous): parse state cleared, match_kind = 254, match_size = 8.
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_option_client_addr_extract
// Top level: APB config registers, option walker and result register.
// ----------------------------------------------------------------------------
module tcp_option_client_addr_extract (
  input  wire logic                              clk,
  input  wire logic                              rst,
  tcpoce_in_if.sink                              option_chan,
  tcpoce_out_if.source                           result_chan,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tcpoce_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic [tcpoce_pkg::KIND_W-1:0] match_kind;
  logic [tcpoce_pkg::SIZE_W-1:0] match_size;
  tcpoce_pkg::reg_idx_t          reg_sel;
  logic                          wr_en;
  tcpoce_pkg::result_stat_t      res;
  logic                          res_ready;

  assign pready  = 1'b1;
  assign reg_sel = tcpoce_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_kind <= tcpoce_pkg::MATCH_KIND_RST;
      match_size <= tcpoce_pkg::MATCH_SIZE_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        tcpoce_pkg::REG_MATCH_KIND: match_kind <= pwdata[tcpoce_pkg::KIND_W-1:0];
        tcpoce_pkg::REG_MATCH_SIZE: match_size <= pwdata[tcpoce_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tcpoce_pkg::REG_MATCH_KIND: prdata = {24'd0, match_kind};
      tcpoce_pkg::REG_MATCH_SIZE: prdata = {26'd0, match_size};
      default:                    prdata = '0;
    endcase
  end

  tcpoce_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .option_chan (option_chan),
    .match_kind  (match_kind),
    .match_size  (match_size),
    .res_ready   (res_ready),
    .res         (res)
  );

  tcpoce_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .res_ready   (res_ready),
    .result_chan (result_chan)
  );

`ifndef SYNTHESIS
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result_chan.valid)
    else $error("result valid right after reset");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    result_chan.valid && !result_chan.found |->
      result_chan.client_port == '0 && result_chan.client_ip == '0)
    else $error("address fields nonzero without a match");

  a_final_byte_yields_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && res_ready |=> result_chan.valid)
    else $error("final byte transfer produced no result");
`endif

endmodule
`default_nettype wire

/* dv/tcp_option_client_addr_extract_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_option_client_addr_extract_tb
// Drives TCP option areas byte by byte through the valid/ready option channel
// and checks every extracted client address against a cycle-free predictor of
// the option walker. A directed table covers the corner cases. Random areas
// follow, mostly well-formed option lists with random content plus noise and
// broken lengths, under several match register settings and idle patterns.
// ----------------------------------------------------------------------------
module tcp_option_client_addr_extract_tb;

  localparam int CLK_HALF      = 10;
  localparam int RST_CYCLES    = 9;
  localparam int DRAIN_CYCLES  = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int PHASE_ITEMS   = 190;
  localparam int NUM_PHASES    = 8;
  localparam int PRESSURE_PH   = 5;
  localparam int BUSY_PCT      = 68;
  localparam int BOTH_PCT      = 31;

  typedef enum logic [1:0] {
    WALK_KIND,
    WALK_LEN,
    WALK_DATA,
    WALK_STOP
  } walk_phase_t;

  typedef struct {
    logic [7:0]          b;
    logic                last;
    bit                  typed;
    tcpoce_pkg::result_t res;
  } dir_row_t;

  localparam tcpoce_pkg::result_t NO_ADDR  = '0;
  localparam tcpoce_pkg::result_t HIT_1234 = {1'b1, 16'h1234, 32'hC0A80102};

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [tcpoce_pkg::PADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  tcpoce_in_if  option_chan ();
  tcpoce_out_if result_chan ();

  tcp_option_client_addr_extract u_top (
    .clk         (clk),
    .rst         (rst),
    .option_chan (option_chan),
    .result_chan (result_chan),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #CLK_HALF clk = ~clk;

  // register mirror and walker state
  logic [tcpoce_pkg::KIND_W-1:0] cfg_kind;
  logic [tcpoce_pkg::SIZE_W-1:0] cfg_size;
  walk_phase_t                   walk_phase;
  logic [5:0]                    opt_left;
  bit                            opt_hit;
  logic [tcpoce_pkg::ADDR_W-1:0] cap_buf;
  int                            cap_idx;
  bit                            have_addr;
  logic [tcpoce_pkg::ADDR_W-1:0] held_addr;

  tcpoce_pkg::result_t pending_results[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      sender_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_seq = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  dir_row_t dir_rows [25] = '{
    '{8'h00, 1'b1, 1'b1, NO_ADDR},
    '{8'hFF, 1'b1, 1'b1, NO_ADDR},
    '{8'hFE, 1'b0, 1'b0, NO_ADDR},
    '{8'h08, 1'b0, 1'b0, NO_ADDR},
    '{8'h12, 1'b0, 1'b0, NO_ADDR},
    '{8'h34, 1'b0, 1'b0, NO_ADDR},
    '{8'hC0, 1'b0, 1'b0, NO_ADDR},
    '{8'hA8, 1'b0, 1'b0, NO_ADDR},
    '{8'h01, 1'b0, 1'b0, NO_ADDR},
    '{8'h02, 1'b1, 1'b1, HIT_1234},
    '{8'hFE, 1'b0, 1'b0, NO_ADDR},
    '{8'h01, 1'b0, 1'b0, NO_ADDR},
    '{8'hFF, 1'b1, 1'b1, NO_ADDR},
    '{8'h03, 1'b0, 1'b0, NO_ADDR},
    '{8'h29, 1'b0, 1'b0, NO_ADDR},
    '{8'h00, 1'b1, 1'b1, NO_ADDR},
    '{8'hFE, 1'b0, 1'b0, NO_ADDR},
    '{8'h08, 1'b0, 1'b0, NO_ADDR},
    '{8'hAA, 1'b0, 1'b0, NO_ADDR},
    '{8'hBB, 1'b0, 1'b0, NO_ADDR},
    '{8'hCC, 1'b1, 1'b1, NO_ADDR},
    '{8'h05, 1'b0, 1'b0, NO_ADDR},
    '{8'h02, 1'b0, 1'b0, NO_ADDR},
    '{8'h01, 1'b0, 1'b0, NO_ADDR},
    '{8'h00, 1'b1, 1'b0, NO_ADDR}
  };

  function automatic void clear_walker();
    walk_phase = WALK_KIND;
    opt_left   = '0;
    opt_hit    = 1'b0;
    cap_buf    = '0;
    cap_idx    = 0;
    have_addr  = 1'b0;
    held_addr  = '0;
  endfunction

  function automatic void walk_option_byte(input logic [7:0] b, input logic last,
                                           output bit emit, output tcpoce_pkg::result_t res);
    case (walk_phase)
      WALK_KIND: begin
        if (b == tcpoce_pkg::KIND_EOL) begin
          walk_phase = WALK_STOP;
        end else if (b != tcpoce_pkg::KIND_NOP) begin
          opt_hit    = (b == cfg_kind);
          walk_phase = WALK_LEN;
        end
      end
      WALK_LEN: begin
        if (b < tcpoce_pkg::OPT_LEN_MIN || b > tcpoce_pkg::OPT_AREA_MAX) begin
          walk_phase = WALK_STOP;
        end else if (b == tcpoce_pkg::OPT_LEN_MIN) begin
          opt_hit    = 1'b0;
          walk_phase = WALK_KIND;
        end else begin
          opt_hit    = opt_hit && (b == 8'(cfg_size))
                       && (b >= tcpoce_pkg::ADDR_OPT_LEN_MIN);
          opt_left   = 6'(b - tcpoce_pkg::OPT_LEN_MIN);
          cap_idx    = 0;
          cap_buf    = '0;
          walk_phase = WALK_DATA;
        end
      end
      WALK_DATA: begin
        if (cap_idx < tcpoce_pkg::CAP_BYTES) begin
          cap_buf = {cap_buf[tcpoce_pkg::ADDR_W-tcpoce_pkg::BYTE_W-1:0], b};
          cap_idx++;
        end
        if (opt_left > 0)
          opt_left--;
        if (opt_left == 0) begin
          if (opt_hit) begin
            have_addr = 1'b1;
            held_addr = cap_buf;
          end
          opt_hit    = 1'b0;
          walk_phase = WALK_KIND;
        end
      end
      default: ;
    endcase
    emit = last;
    res  = have_addr ? {1'b1, held_addr} : NO_ADDR;
    if (last)
      clear_walker();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic send_option_byte(input logic [7:0] b, input logic last, input bit typed,
                                  input tcpoce_pkg::result_t typed_res);
    bit                  emit;
    tcpoce_pkg::result_t res;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      option_chan.valid <= 1'b0;
      @(posedge clk);
    end
    option_chan.valid       <= 1'b1;
    option_chan.option_byte <= b;
    option_chan.area_end    <= last;
    @(posedge clk);
    while (!option_chan.ready) @(posedge clk);
    walk_option_byte(b, last, emit, res);
    if (emit)
      pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic apb_write(input tcpoce_pkg::reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == tcpoce_pkg::REG_MATCH_KIND) ? 32'hFF : 32'h3F;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tcpoce_pkg::PADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) != (value & mask))
      report_mismatch("register read back", prdata & mask, value & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == tcpoce_pkg::REG_MATCH_KIND)
      cfg_kind = value[tcpoce_pkg::KIND_W-1:0];
    else
      cfg_size = value[tcpoce_pkg::SIZE_W-1:0];
    @(posedge clk);
  endtask

  function automatic void push_option(ref logic [7:0] area[$], input logic [7:0] kind,
                                      input int len);
    area.push_back(kind);
    area.push_back(8'(len));
    for (int i = 2; i < len; i++)
      area.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_area(input bit short_only, ref logic [7:0] area[$]);
    int style;
    int target;
    area.delete();
    style  = $urandom_range(0, 9);
    target = short_only ? $urandom_range(1, 3) : $urandom_range(1, 40);
    if (style == 9) begin
      area.push_back(8'($urandom_range(2, 255)));
      area.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                          : 8'($urandom_range(41, 255)));
    end
    if (style >= 7) begin
      while (area.size() < target)
        area.push_back(8'($urandom_range(0, 255)));
    end else begin
      while (area.size() < target) begin
        case ($urandom_range(0, 9))
          0:       area.push_back(tcpoce_pkg::KIND_NOP);
          1:       area.push_back(tcpoce_pkg::KIND_EOL);
          2, 3:    push_option(area, 8'($urandom_range(2, 255)), $urandom_range(2, 12));
          4:       push_option(area, cfg_kind, $urandom_range(2, 16));
          default: push_option(area, cfg_kind, int'(cfg_size));
        endcase
      end
      if ($urandom_range(0, 1))
        while (area.size() > target) void'(area.pop_back());
    end
  endfunction

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_chan.ready <= 1'b0;
    end else begin
      result_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    tcpoce_pkg::result_t want;
    if (!rst && result_chan.valid && result_chan.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result",
                        {result_chan.found, result_chan.client_port, result_chan.client_ip},
                        '0);
      end else begin
        want = pending_results.pop_front();
        if (result_chan.found !== want.found)
          report_mismatch("found", result_chan.found, want.found);
        if (result_chan.client_port !== want.client_port)
          report_mismatch("client_port", result_chan.client_port, want.client_port);
        if (result_chan.client_ip !== want.client_ip)
          report_mismatch("client_ip", result_chan.client_ip, want.client_ip);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tcp_option_client_addr_extract regression: fail");
      $finish;
    end
  end

  initial begin
    logic [7:0]                    area[$];
    int                            phase_items;
    logic [tcpoce_pkg::KIND_W-1:0] new_kind;
    logic [tcpoce_pkg::SIZE_W-1:0] new_size;

    rst                     <= 1'b1;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    option_chan.valid       <= 1'b0;
    option_chan.option_byte <= '0;
    option_chan.area_end    <= 1'b0;
    cfg_kind = tcpoce_pkg::MATCH_KIND_RST;
    cfg_size = tcpoce_pkg::MATCH_SIZE_RST;
    clear_walker();
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_option_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
    option_chan.valid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      while (pending_results.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      case (ph)
        0: begin
          new_kind = tcpoce_pkg::MATCH_KIND_RST;
          new_size = tcpoce_pkg::MATCH_SIZE_RST;
        end
        1: begin new_kind = tcpoce_pkg::KIND_EOL; new_size = 6'd40; end
        2: begin new_kind = 8'hFF;                new_size = 6'd40; end
        3: begin new_kind = 8'($urandom_range(2, 255)); new_size = 6'd5; end
        4: begin new_kind = 8'($urandom_range(2, 255)); new_size = 6'd45; end
        5: begin new_kind = tcpoce_pkg::KIND_NOP; new_size = 6'd8; end
        6: begin
          new_kind = 8'($urandom_range(2, 255));
          new_size = 6'($urandom_range(8, 40));
        end
        default: begin new_kind = 8'd253; new_size = 6'd12; end
      endcase
      apb_write(tcpoce_pkg::REG_MATCH_KIND, 32'(new_kind));
      apb_write(tcpoce_pkg::REG_MATCH_SIZE, 32'(new_size));

      case (ph % 4)
        0:       begin sender_idle_pct = 0;        recv_stall_pct = 0; end
        1:       begin sender_idle_pct = BUSY_PCT; recv_stall_pct = 0; end
        2:       begin sender_idle_pct = 0;        recv_stall_pct = BUSY_PCT; end
        default: begin sender_idle_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT; end
      endcase
      if (ph == PRESSURE_PH) begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_seq <= hold_seq + 1;
      end

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_area(ph == PRESSURE_PH, area);
        foreach (area[i])
          send_option_byte(area[i], i == area.size() - 1, 1'b0, NO_ADDR);
        phase_items += area.size();
      end
      option_chan.valid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tcp_option_client_addr_extract regression: pass");
    else
      $display("tcp_option_client_addr_extract regression: fail");
    $finish;
  end

endmodule

/* sim.f */
design/tcpoce_pkg.sv
design/tcpoce_if.sv
design/tcpoce_parser.sv
design/tcpoce_out_reg.sv
design/tcp_option_client_addr_extract.sv
dv/tcp_option_client_addr_extract_tb.sv
